[rtl/packet_framer_crc16_defines.svh]
// assertion macros for the packet framer
`ifndef PACKET_FRAMER_CRC16_DEFINES_SVH
`define PACKET_FRAMER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PFC_ASSERT(lbl, prop, msg)
`define PFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/pfc_pkg.sv]
`timescale 1ns / 1ps

package pfc_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0] LenOverhead = 8'd2;

  localparam logic [7:0] SyncFirstReset = 8'hAA;
  localparam logic [7:0] SyncSecondReset = 8'h55;
  localparam logic [7:0] MaxPayloadReset = 8'd64;
  localparam logic [15:0] CrcSeedReset = 16'hFFFF;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] RegSyncFirst = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegSyncSecond = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegMaxPayload = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegCrcSeed = 2'd3;

  localparam logic OpHeader = 1'b0;
  localparam logic OpPayload = 1'b1;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatTooLong = 2'd1;
  localparam logic [1:0] StatStray = 2'd2;
  localparam logic [1:0] StatOpen = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYNC2,
    ST_LEN,
    ST_ID,
    ST_SEQ,
    ST_CRC_HI,
    ST_CRC_LO
  } emit_state_e;

  // one byte through the ccitt crc, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/packet_framer_crc16.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    op_i, message_id_i, payload_length_i,
//                                                 payload_byte_i
// out       output     out_valid_o / out_stall_i  frame_byte_o, frame_end_o, status_o,
//                                                 next_sequence_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// the emit sequencer gives one byte per cycle unless out_stall_i holds it; a payload or
// error item gives one byte, a header two sync, len, id and seq bytes plus the crc if
// empty, the last payload item the crc; the crc is updated as each covered byte is emitted
// in_stall_o is high while the sequencer runs or the output register is held
// rst_ni clears frame state, sequence counter and registers to defaults; no clearing pass
`include "packet_framer_crc16_defines.svh"

module packet_framer_crc16 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [pfc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [7:0]                          message_id_i,
  input  logic [7:0]                          payload_length_i,
  input  logic [7:0]                          payload_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          frame_byte_o,
  output logic                                frame_end_o,
  output logic [1:0]                          status_o,
  output logic [7:0]                          next_sequence_o
);

  logic [7:0] sync_first_q, sync_second_q, max_payload_q;
  logic [15:0] crc_seed_q;

  pfc_pkg::emit_state_e state_q, state_d;
  logic [7:0] seq_q, seq_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0] rem_q, rem_d;
  logic open_q, open_d;
  logic [7:0] hdr_id_q, hdr_id_d;
  logic [7:0] hdr_len_q, hdr_len_d;
  logic [7:0] hdr_seq_q, hdr_seq_d;

  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic out_end_q, out_end_d;
  logic [1:0] out_status_q, out_status_d;
  logic [7:0] out_nseq_q, out_nseq_d;

  logic adv;
  logic in_accept;

  assign adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != pfc_pkg::ST_IDLE) || !adv;
  assign in_accept = in_valid_i && !in_stall_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q <= pfc_pkg::SyncFirstReset;
      sync_second_q <= pfc_pkg::SyncSecondReset;
      max_payload_q <= pfc_pkg::MaxPayloadReset;
      crc_seed_q <= pfc_pkg::CrcSeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfc_pkg::RegSyncFirst: sync_first_q <= cfg_data_i[7:0];
        pfc_pkg::RegSyncSecond: sync_second_q <= cfg_data_i[7:0];
        pfc_pkg::RegMaxPayload: max_payload_q <= cfg_data_i[7:0];
        pfc_pkg::RegCrcSeed: crc_seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    seq_d = seq_q;
    crc_d = crc_q;
    rem_d = rem_q;
    open_d = open_q;
    hdr_id_d = hdr_id_q;
    hdr_len_d = hdr_len_q;
    hdr_seq_d = hdr_seq_q;
    out_valid_d = out_valid_q && !adv;
    out_byte_d = out_byte_q;
    out_end_d = out_end_q;
    out_status_d = out_status_q;
    if (adv) begin
      unique case (state_q)
        pfc_pkg::ST_IDLE: begin
          if (in_accept) begin
            out_valid_d = 1'b1;
            out_byte_d = 8'h00;
            out_end_d = 1'b1;
            out_status_d = pfc_pkg::StatOk;
            if (op_i == pfc_pkg::OpHeader) begin
              if (open_q) begin
                out_status_d = pfc_pkg::StatOpen;
              end else if (payload_length_i > max_payload_q) begin
                out_status_d = pfc_pkg::StatTooLong;
              end else begin
                out_byte_d = sync_first_q;
                out_end_d = 1'b0;
                seq_d = seq_q + 8'd1;
                crc_d = crc_seed_q;
                rem_d = payload_length_i;
                open_d = 1'b1;
                hdr_id_d = message_id_i;
                hdr_len_d = payload_length_i + pfc_pkg::LenOverhead;
                hdr_seq_d = seq_q;
                state_d = pfc_pkg::ST_SYNC2;
              end
            end else begin
              if (!open_q || rem_q == 8'd0) begin
                out_status_d = pfc_pkg::StatStray;
              end else begin
                out_byte_d = payload_byte_i;
                out_end_d = 1'b0;
                crc_d = pfc_pkg::crc_feed(crc_q, payload_byte_i);
                rem_d = rem_q - 8'd1;
                if (rem_q == 8'd1) begin
                  state_d = pfc_pkg::ST_CRC_HI;
                end
              end
            end
          end
        end
        pfc_pkg::ST_SYNC2: begin
          out_valid_d = 1'b1;
          out_byte_d = sync_second_q;
          out_end_d = 1'b0;
          out_status_d = pfc_pkg::StatOk;
          state_d = pfc_pkg::ST_LEN;
        end
        pfc_pkg::ST_LEN: begin
          out_valid_d = 1'b1;
          out_byte_d = hdr_len_q;
          out_end_d = 1'b0;
          out_status_d = pfc_pkg::StatOk;
          crc_d = pfc_pkg::crc_feed(crc_q, hdr_len_q);
          state_d = pfc_pkg::ST_ID;
        end
        pfc_pkg::ST_ID: begin
          out_valid_d = 1'b1;
          out_byte_d = hdr_id_q;
          out_end_d = 1'b0;
          out_status_d = pfc_pkg::StatOk;
          crc_d = pfc_pkg::crc_feed(crc_q, hdr_id_q);
          state_d = pfc_pkg::ST_SEQ;
        end
        pfc_pkg::ST_SEQ: begin
          out_valid_d = 1'b1;
          out_byte_d = hdr_seq_q;
          out_end_d = 1'b0;
          out_status_d = pfc_pkg::StatOk;
          crc_d = pfc_pkg::crc_feed(crc_q, hdr_seq_q);
          state_d = (rem_q == 8'd0) ? pfc_pkg::ST_CRC_HI : pfc_pkg::ST_IDLE;
        end
        pfc_pkg::ST_CRC_HI: begin
          out_valid_d = 1'b1;
          out_byte_d = crc_q[15:8];
          out_end_d = 1'b0;
          out_status_d = pfc_pkg::StatOk;
          state_d = pfc_pkg::ST_CRC_LO;
        end
        pfc_pkg::ST_CRC_LO: begin
          out_valid_d = 1'b1;
          out_byte_d = crc_q[7:0];
          out_end_d = 1'b1;
          out_status_d = pfc_pkg::StatOk;
          open_d = 1'b0;
          state_d = pfc_pkg::ST_IDLE;
        end
        default: state_d = pfc_pkg::ST_IDLE;
      endcase
    end
    out_nseq_d = (adv && out_valid_d) ? seq_d : out_nseq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfc_pkg::ST_IDLE;
      seq_q <= 8'd0;
      crc_q <= 16'd0;
      rem_q <= 8'd0;
      open_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seq_q <= seq_d;
      crc_q <= crc_d;
      rem_q <= rem_d;
      open_q <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hdr_id_q <= hdr_id_d;
    hdr_len_q <= hdr_len_d;
    hdr_seq_q <= hdr_seq_d;
    out_byte_q <= out_byte_d;
    out_end_q <= out_end_d;
    out_status_q <= out_status_d;
    out_nseq_q <= out_nseq_d;
  end

  assign out_valid_o = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_end_o = out_end_q;
  assign status_o = out_status_q;
  assign next_sequence_o = out_nseq_q;

  `PFC_ASSERT(a_busy_stalls, (state_q != pfc_pkg::ST_IDLE) |-> in_stall_o, "input taken mid-frame")
  `PFC_ASSERT(a_closed_empty, !open_q |-> (rem_q == 8'd0), "closed frame with bytes left")
  `PFC_ASSERT(a_crc_ready, (state_q == pfc_pkg::ST_CRC_HI) |-> (open_q && rem_q == 8'd0), "crc out of order")
  `PFC_ASSERT(a_end_closes, (out_valid_q && out_end_q && out_status_q == pfc_pkg::StatOk) |-> !open_q, "frame left open after crc")
  `PFC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_q && state_q == pfc_pkg::ST_IDLE), "not idle in reset")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 5;
  localparam int ScriptLen = 17;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       fend;
    logic [1:0] stat;
    logic [7:0] nseq;
  } frame_res_t;

  typedef struct packed {
    logic       op;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] pb;
    logic       fixed;
    frame_res_t res;
  } stim_row_t;

  localparam frame_res_t NoRes = '{default: '0};

  // typed rows hold their one expected result, the rest go through the predictor
  localparam stim_row_t Script [ScriptLen] = '{
    '{pfc_pkg::OpPayload, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatStray, 8'h00}},
    '{pfc_pkg::OpHeader, 8'h00, 8'h00, 8'hFF, 1'b0, NoRes},
    '{pfc_pkg::OpHeader, 8'hFF, 8'd65, 8'h00, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatTooLong, 8'h01}},
    '{pfc_pkg::OpHeader, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatTooLong, 8'h01}},
    '{pfc_pkg::OpHeader, 8'h5A, 8'h01, 8'h00, 1'b0, NoRes},
    '{pfc_pkg::OpHeader, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatOpen, 8'h02}},
    '{pfc_pkg::OpPayload, 8'h00, 8'h00, 8'hFF, 1'b0, NoRes},
    '{pfc_pkg::OpPayload, 8'hFF, 8'hFF, 8'h00, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatStray, 8'h02}},
    '{pfc_pkg::OpHeader, 8'hC3, 8'h03, 8'hFF, 1'b0, NoRes},
    '{pfc_pkg::OpPayload, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{pfc_pkg::OpHeader, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatOpen, 8'h03}},
    '{pfc_pkg::OpPayload, 8'hFF, 8'hFF, 8'h80, 1'b0, NoRes},
    '{pfc_pkg::OpPayload, 8'h00, 8'h00, 8'h7F, 1'b0, NoRes},
    '{pfc_pkg::OpHeader, 8'h81, 8'd2, 8'h00, 1'b0, NoRes},
    '{pfc_pkg::OpHeader, 8'h00, 8'd64, 8'h00, 1'b1, '{8'h00, 1'b1, pfc_pkg::StatOpen, 8'h04}},
    '{pfc_pkg::OpPayload, 8'hFF, 8'hFF, 8'h01, 1'b0, NoRes},
    '{pfc_pkg::OpPayload, 8'h00, 8'h00, 8'hFE, 1'b0, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_n = 1'b1;
  logic cfg_we = 1'b0;
  logic [pfc_pkg::CfgIdxWidth-1:0] cfg_idx = '0;
  logic [pfc_pkg::CfgDataWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic op = 1'b0;
  logic [7:0] msg_id = '0;
  logic [7:0] pay_len = '0;
  logic [7:0] pay_byte = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic [7:0] frame_byte_o;
  logic frame_end_o;
  logic [1:0] status_o;
  logic [7:0] next_sequence_o;

  logic cur_fixed = 1'b0;
  frame_res_t cur_res = '0;
  logic no_gaps = 1'b0;
  int out_hold = 0;
  int items_sent = 0;
  int errors = 0;
  int cycle_cnt = 0;

  // predictor copy of the registers and frame state
  logic [7:0] cfg_sync1 = pfc_pkg::SyncFirstReset;
  logic [7:0] cfg_sync2 = pfc_pkg::SyncSecondReset;
  logic [7:0] cfg_max = pfc_pkg::MaxPayloadReset;
  logic [15:0] cfg_seed = pfc_pkg::CrcSeedReset;
  logic [7:0] seq_cnt = '0;
  logic [15:0] crc_acc = '0;
  logic [7:0] remaining = '0;
  logic frm_open = 1'b0;

  frame_res_t step_res [7];
  int step_n;
  frame_res_t expected_q [$];

  packet_framer_crc16 u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .op_i            (op),
    .message_id_i    (msg_id),
    .payload_length_i(pay_len),
    .payload_byte_i  (pay_byte),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .frame_byte_o    (frame_byte_o),
    .frame_end_o     (frame_end_o),
    .status_o        (status_o),
    .next_sequence_o (next_sequence_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int b = 7; b >= 0; b--) begin
      fb = acc[15] ^ d[b];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ pfc_pkg::CrcPoly;
      end
    end
    return acc;
  endfunction

  task automatic add_res(input logic [7:0] b, input logic e, input logic [1:0] s);
    step_res[step_n] = '{b, e, s, seq_cnt};
    step_n++;
  endtask

  task automatic close_frame();
    add_res(crc_acc[15:8], 1'b0, pfc_pkg::StatOk);
    add_res(crc_acc[7:0], 1'b1, pfc_pkg::StatOk);
    frm_open = 1'b0;
  endtask

  task automatic frame_predict(input logic f_op, input logic [7:0] id, input logic [7:0] len,
                               input logic [7:0] pb);
    logic [7:0] lenb;
    logic [7:0] seqv;
    step_n = 0;
    if (f_op == pfc_pkg::OpHeader) begin
      if (frm_open) begin
        add_res(8'h00, 1'b1, pfc_pkg::StatOpen);
      end else if (len > cfg_max) begin
        add_res(8'h00, 1'b1, pfc_pkg::StatTooLong);
      end else begin
        lenb = len + pfc_pkg::LenOverhead;
        seqv = seq_cnt;
        seq_cnt = seq_cnt + 8'd1;
        crc_acc = crc_step(crc_step(crc_step(cfg_seed, lenb), id), seqv);
        remaining = len;
        frm_open = 1'b1;
        add_res(cfg_sync1, 1'b0, pfc_pkg::StatOk);
        add_res(cfg_sync2, 1'b0, pfc_pkg::StatOk);
        add_res(lenb, 1'b0, pfc_pkg::StatOk);
        add_res(id, 1'b0, pfc_pkg::StatOk);
        add_res(seqv, 1'b0, pfc_pkg::StatOk);
        if (remaining == 8'd0) begin
          close_frame();
        end
      end
    end else if (!frm_open || remaining == 8'd0) begin
      add_res(8'h00, 1'b1, pfc_pkg::StatStray);
    end else begin
      crc_acc = crc_step(crc_acc, pb);
      remaining = remaining - 8'd1;
      add_res(pb, 1'b0, pfc_pkg::StatOk);
      if (remaining == 8'd0) begin
        close_frame();
      end
    end
  endtask

  always @(posedge clk_i) begin : monitor
    frame_res_t got;
    frame_res_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          pfc_pkg::RegSyncFirst: cfg_sync1 = cfg_data[7:0];
          pfc_pkg::RegSyncSecond: cfg_sync2 = cfg_data[7:0];
          pfc_pkg::RegMaxPayload: cfg_max = cfg_data[7:0];
          pfc_pkg::RegCrcSeed: cfg_seed = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall_o) begin
        frame_predict(op, msg_id, pay_len, pay_byte);
        if (cur_fixed) begin
          expected_q.push_back(cur_res);
        end else begin
          for (int k = 0; k < step_n; k++) begin
            expected_q.push_back(step_res[k]);
          end
        end
      end
      if (out_valid_o && !out_stall) begin
        got = '{frame_byte_o, frame_end_o, status_o, next_sequence_o};
        out_hold = no_gaps ? 0 : $urandom_range(0, 5);
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected item: byte %h end %b status %0d seq %h",
                     got.fbyte, got.fend, got.stat, got.nseq);
          end
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: want byte %h end %b status %0d seq %h, got %h %b %0d %h",
                       want.fbyte, want.fend, want.stat, want.nseq,
                       got.fbyte, got.fend, got.stat, got.nseq);
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("packet_framer_crc16 verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic s_op, input logic [7:0] id, input logic [7:0] len,
                           input logic [7:0] pb, input logic fixed, input frame_res_t res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    op <= s_op;
    msg_id <= id;
    pay_len <= len;
    pay_byte <= pb;
    cur_fixed <= fixed;
    cur_res <= res;
    do @(posedge clk_i); while (!(in_valid && !in_stall_o));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pfc_pkg::CfgIdxWidth-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] mx,
                          input logic [15:0] seed);
    drain();
    write_reg(pfc_pkg::RegSyncFirst, {8'h00, s1});
    write_reg(pfc_pkg::RegSyncSecond, {8'h00, s2});
    write_reg(pfc_pkg::RegMaxPayload, {8'h00, mx});
    write_reg(pfc_pkg::RegCrcSeed, seed);
  endtask

  // mostly well-formed frames, with oversized, stray and nested headers mixed in
  task automatic build_frame();
    int len;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8 && cfg_max < 8'd255) begin
      send_item(pfc_pkg::OpHeader, rnd8(), 8'($urandom_range(int'(cfg_max) + 1, 255)), rnd8(),
                1'b0, NoRes);
      return;
    end
    if (roll < 14) begin
      send_item(pfc_pkg::OpPayload, rnd8(), rnd8(), rnd8(), 1'b0, NoRes);
      return;
    end
    if (roll < 20 && cfg_max <= 8'd16) begin
      len = cfg_max;
    end else begin
      len = $urandom_range(0, (cfg_max < 8'd8) ? int'(cfg_max) : 8);
    end
    send_item(pfc_pkg::OpHeader, rnd8(), 8'(len), rnd8(), 1'b0, NoRes);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(pfc_pkg::OpHeader, rnd8(), rnd8(), rnd8(), 1'b0, NoRes);
      end
      send_item(pfc_pkg::OpPayload, rnd8(), rnd8(), rnd8(), 1'b0, NoRes);
    end
  endtask

  initial begin
    int start;
    #1;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    for (int r = 0; r < ScriptLen; r++) begin
      send_item(Script[r].op, Script[r].id, Script[r].len, Script[r].pb,
                Script[r].fixed, Script[r].res);
    end

    // length byte wraps to zero
    set_regs(rnd8(), rnd8(), 8'd255, 16'($urandom_range(0, 65535)));
    send_item(pfc_pkg::OpHeader, rnd8(), 8'd254, rnd8(), 1'b0, NoRes);
    for (int i = 0; i < 254; i++) begin
      send_item(pfc_pkg::OpPayload, rnd8(), rnd8(), rnd8(), 1'b0, NoRes);
    end
    send_item(pfc_pkg::OpPayload, rnd8(), rnd8(), rnd8(), 1'b0, NoRes);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(8'h00, 8'hFF, 8'd0, 16'h0000);
        1: set_regs(8'hFF, 8'h00, 8'd253, 16'hFFFF);
        4: set_regs(rnd8(), rnd8(), 8'd1, 16'($urandom_range(0, 65535)));
        5: set_regs(rnd8(), rnd8(), 8'd253, 16'($urandom_range(0, 65535)));
        default: set_regs(rnd8(), rnd8(), 8'($urandom_range(0, 12)),
                          16'($urandom_range(0, 65535)));
      endcase
      no_gaps = (ph == 3 || ph == 6);
      start = items_sent;
      while (items_sent - start < PhaseItems) build_frame();
    end

    drain();
    if (errors == 0) begin
      $display("packet_framer_crc16 verification clean");
    end else begin
      $display("packet_framer_crc16 verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pfc_pkg.sv
rtl/packet_framer_crc16.sv
bench/tb_top.sv
